/* design/kart_pkg.sv */
// Shared types and constants of the key auto-repeat table.
`default_nettype none
package kart_pkg;

  localparam int KEY_W  = 9;
  localparam int TIME_W = 32;
  localparam int DLY_W  = 21;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TIME_W-1:0] stamp_t;
  typedef logic [DLY_W-1:0]  delay_t;

  typedef struct packed {
    key_t   key;
    stamp_t stamp;
    logic   rep;
  } entry_t;

  typedef struct packed {
    key_t key;
    logic rep;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_CHK,
    ST_REL_RD,
    ST_REL_CHK,
    ST_REL_MOVE,
    ST_DONE
  } state_t;

  localparam logic OP_POLL    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic REG_FIRST_DELAY     = 1'b0;
  localparam logic REG_REPEAT_INTERVAL = 1'b1;

  localparam delay_t FIRST_DELAY_RST     = 21'd500000;
  localparam delay_t REPEAT_INTERVAL_RST = 21'd50000;

endpackage
`default_nettype wire

/* design/key_auto_repeat_table.sv */
// Top level of the key auto-repeat table.
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   opcode, key_code, now_us
//   output    out_valid  out_stall  out_key, is_repeat
//   config    wr_en      -          wr_index, wr_data
//
// Press, or any request on an empty table: goes straight to the result.
// Poll: checks entries in turn until one is due or the last one has been checked.
// Release: checks entries in turn; each gap is refilled from the tail and its slot checked again.
// Every entry goes through the table's single read port and one due comparator.
// Reset empties the table at once; the delays return to 500000 and 50000 us.
// One request at a time; a finished result waits in the output register while
// the next request is accepted.
`default_nettype none
module key_auto_repeat_table #(
  parameter int TABLE_DEPTH = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  opcode,
  input  wire logic [8:0]            key_code,
  input  wire logic [31:0]           now_us,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [8:0]                 out_key,
  output logic                       is_repeat,
  input  wire logic                  wr_en,
  input  wire logic                  wr_index,
  input  wire logic [20:0]           wr_data
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  kart_pkg::delay_t first_delay, repeat_interval;
  kart_pkg::entry_t rd_entry, wdata;
  kart_pkg::res_t   res;
  kart_pkg::stamp_t cur_now;
  logic             accept, take, busy, done, due, mem_we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [CntW-1:0]  count;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy;
  assign take     = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay     <= kart_pkg::FIRST_DELAY_RST;
      repeat_interval <= kart_pkg::REPEAT_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        kart_pkg::REG_FIRST_DELAY:     first_delay     <= wr_data;
        kart_pkg::REG_REPEAT_INTERVAL: repeat_interval <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && take) begin
      out_key   <= res.key;
      is_repeat <= res.rep;
    end
  end

  kart_table #(
    .DEPTH(TABLE_DEPTH),
    .IW   (IdxW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_entry)
  );

  kart_due u_due (
    .now            (cur_now),
    .stamp          (rd_entry.stamp),
    .rep            (rd_entry.rep),
    .first_delay    (first_delay),
    .repeat_interval(repeat_interval),
    .due            (due)
  );

  kart_ctrl #(
    .DEPTH(TABLE_DEPTH),
    .IW   (IdxW),
    .CW   (CntW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .opcode  (opcode),
    .key_code(key_code),
    .now_us  (now_us),
    .rd_entry(rd_entry),
    .due     (due),
    .take    (take),
    .busy    (busy),
    .done    (done),
    .res     (res),
    .cur_now (cur_now),
    .mem_we  (mem_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .count   (count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("block took no time over an accepted request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !done)
    else $error("result finished with no request pending");

  a_repeat_has_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_repeat |-> out_key != '0)
    else $error("repeat reported without a key");

endmodule
`default_nettype wire

/* design/kart_table.sv */
// Held-key table memory: one write port, one registered read port.
`default_nettype none
module kart_table #(
  parameter int DEPTH = 10,
  parameter int IW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IW-1:0]   waddr,
  input  wire kart_pkg::entry_t wdata,
  input  wire logic [IW-1:0]   raddr,
  output kart_pkg::entry_t     rdata
);

  kart_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/kart_due.sv */
// Shared due check: modular elapsed time against the entry's delay.
`default_nettype none
module kart_due (
  input  wire kart_pkg::stamp_t now,
  input  wire kart_pkg::stamp_t stamp,
  input  wire logic             rep,
  input  wire kart_pkg::delay_t first_delay,
  input  wire kart_pkg::delay_t repeat_interval,
  output logic                  due
);

  kart_pkg::stamp_t elapsed;
  kart_pkg::delay_t delay;

  always_comb begin
    elapsed = now - stamp;
    delay   = rep ? repeat_interval : first_delay;
    due     = elapsed > {{(kart_pkg::TIME_W-kart_pkg::DLY_W){1'b0}}, delay};
  end

endmodule
`default_nettype wire

/* design/kart_ctrl.sv */
// Sequencer: press, poll scan and release over the held-key table.
`default_nettype none
module kart_ctrl #(
  parameter int DEPTH = 10,
  parameter int IW    = 4,
  parameter int CW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic             opcode,
  input  wire kart_pkg::key_t   key_code,
  input  wire kart_pkg::stamp_t now_us,
  input  wire kart_pkg::entry_t rd_entry,
  input  wire logic             due,
  input  wire logic             take,
  output logic                  busy,
  output logic                  done,
  output kart_pkg::res_t        res,
  output kart_pkg::stamp_t      cur_now,
  output logic                  mem_we,
  output logic [IW-1:0]         waddr,
  output kart_pkg::entry_t      wdata,
  output logic [IW-1:0]         raddr,
  output logic [CW-1:0]         count
);

  kart_pkg::state_t state, state_next;
  logic [CW-1:0]    idx, idx_next, count_next, idx_inc, count_dec;
  kart_pkg::res_t   res_next;
  kart_pkg::key_t   cur_key;
  logic             last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kart_pkg::ST_IDLE;
      idx   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      cur_key <= key_code;
      cur_now <= now_us;
    end
  end

  always_comb begin
    idx_inc    = idx + 1'b1;
    count_dec  = count - 1'b1;
    last       = (idx_inc == count);
    state_next = state;
    idx_next   = idx;
    count_next = count;
    res_next   = res;
    mem_we     = 1'b0;
    waddr      = idx[IW-1:0];
    wdata      = rd_entry;
    raddr      = idx[IW-1:0];
    busy       = (state != kart_pkg::ST_IDLE);
    done       = 1'b0;
    unique case (state)
      kart_pkg::ST_IDLE: begin
        raddr = '0;
        if (accept) begin
          idx_next = '0;
          res_next = '0;
          if (opcode == kart_pkg::OP_RELEASE) begin
            state_next = (count == '0) ? kart_pkg::ST_DONE : kart_pkg::ST_REL_CHK;
          end else if (key_code != '0) begin
            // press: append when there is room, report regardless
            if (count < CW'(DEPTH)) begin
              mem_we     = 1'b1;
              waddr      = count[IW-1:0];
              wdata      = '{key: key_code, stamp: now_us, rep: 1'b0};
              count_next = count + 1'b1;
            end
            res_next   = '{key: key_code, rep: 1'b0};
            state_next = kart_pkg::ST_DONE;
          end else begin
            state_next = (count == '0) ? kart_pkg::ST_DONE : kart_pkg::ST_SCAN_CHK;
          end
        end
      end
      kart_pkg::ST_SCAN_CHK: begin
        if (due) begin
          mem_we     = 1'b1;
          wdata      = '{key: rd_entry.key, stamp: cur_now, rep: 1'b1};
          res_next   = '{key: rd_entry.key, rep: 1'b1};
          state_next = kart_pkg::ST_DONE;
        end else if (last) begin
          state_next = kart_pkg::ST_DONE;
        end else begin
          // fetch the next entry while this one is checked
          idx_next = idx_inc;
          raddr    = idx_inc[IW-1:0];
        end
      end
      kart_pkg::ST_REL_RD: begin
        state_next = kart_pkg::ST_REL_CHK;
      end
      kart_pkg::ST_REL_CHK: begin
        if (rd_entry.key == cur_key) begin
          if (last) begin
            count_next = count_dec;
            state_next = kart_pkg::ST_DONE;
          end else begin
            raddr      = count_dec[IW-1:0];
            state_next = kart_pkg::ST_REL_MOVE;
          end
        end else if (last) begin
          state_next = kart_pkg::ST_DONE;
        end else begin
          idx_next = idx_inc;
          raddr    = idx_inc[IW-1:0];
        end
      end
      kart_pkg::ST_REL_MOVE: begin
        // move the last entry into the gap, then check the same slot again
        mem_we     = 1'b1;
        count_next = count_dec;
        state_next = kart_pkg::ST_REL_RD;
      end
      kart_pkg::ST_DONE: begin
        done = 1'b1;
        if (take) begin
          state_next = kart_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kart_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
